// ===== src/ckbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckbs_pkg: shared types and constants of the keyframe blend selector
// Beat layouts of the request and response channels, opcode names and the
// Q16 constants used by the sequencer and the divider.
// ----------------------------------------------------------------------------
package ckbs_pkg;

   // default number of keyframe slots
   localparam int MAX_KEYFRAMES_DEF = 16;

   // field widths
   localparam int CSR_W   = 5;
   localparam int TIME_W  = 16;
   localparam int BLEND_W = 17;
   localparam int ARITH_W = 18;

   // request opcodes
   localparam logic OPCODE_LOAD  = 1'b0;
   localparam logic OPCODE_QUERY = 1'b1;

   // Q16 one and one half, in the signed arithmetic width
   localparam logic signed [ARITH_W-1:0] Q_ONE  = 18'sd65536;
   localparam logic signed [ARITH_W-1:0] Q_HALF = 18'sd32768;

   // quotient bits produced by the serial divider
   localparam int DIV_STEPS = 16;

   typedef struct packed {
      logic              opcode;
      logic [3:0]        slot;
      logic [TIME_W-1:0] key_time;
      logic              crossfade;
      logic [TIME_W-1:0] day_fraction;
   } ckbs_req_type;

   typedef struct packed {
      logic [3:0]         bottom_index;
      logic [3:0]         top_index;
      logic               top_valid;
      logic [BLEND_W-1:0] blend_factor;
   } ckbs_rsp_type;

endpackage

// ===== src/ckbs_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckbs_div: serial Q16 ratio unit
// Computes floor(num * 65536 / den) saturated to 65536, one quotient bit per
// cycle by restoring division. A divisor or numerator that is not positive
// gives zero.
// ----------------------------------------------------------------------------
module ckbs_div
   import ckbs_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [ARITH_W-1:0] num,
   input  logic signed [ARITH_W-1:0] den,
   output logic                      done,
   output logic [BLEND_W-1:0]        quot
);

   localparam int STEP_W = $clog2(DIV_STEPS);

   typedef enum logic {
      D_IDLE,
      D_RUN
   } div_state_type;

   div_state_type          state_ff, state_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic [BLEND_W-1:0]     rem_ff, rem_in;
   logic [BLEND_W-1:0]     den_ff, den_in;
   logic [DIV_STEPS-1:0]   quo_ff, quo_in;
   logic [BLEND_W-1:0]     quot_ff, quot_in;
   logic                   done_ff, done_in;
   logic [ARITH_W-1:0]     rem_dbl;
   logic [ARITH_W-1:0]     rem_sub;
   logic                   rem_ge;

   // one restoring step: shift the remainder, subtract the divisor if it fits
   assign rem_dbl = {rem_ff, 1'b0};
   assign rem_sub = rem_dbl - {1'b0, den_ff};
   assign rem_ge  = (rem_dbl >= {1'b0, den_ff});

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         D_IDLE: begin
            if (start) begin
               if ((den <= 0) || (num <= 0)) begin
                  quot_in = '0;
                  done_in = 1'b1;
               end else if (num >= den) begin
                  quot_in = BLEND_W'(Q_ONE);
                  done_in = 1'b1;
               end else begin
                  rem_in   = num[BLEND_W-1:0];
                  den_in   = den[BLEND_W-1:0];
                  quo_in   = '0;
                  step_in  = STEP_W'(DIV_STEPS - 1);
                  state_in = D_RUN;
               end
            end
         end
         D_RUN: begin
            rem_in = rem_ge ? rem_sub[BLEND_W-1:0] : rem_dbl[BLEND_W-1:0];
            quo_in = {quo_ff[DIV_STEPS-2:0], rem_ge};
            if (step_ff == '0) begin
               quot_in  = {1'b0, quo_ff[DIV_STEPS-2:0], rem_ge};
               done_in  = 1'b1;
               state_in = D_IDLE;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         default: state_in = D_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
      quot_ff <= quot_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ===== src/circular_keyframe_blend_selector_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_keyframe_blend_selector_core: keyframe lookup and blend factor
// Keeps a circular keyframe table and answers time-of-day queries with the
// current and next keyframe and a Q16 cross-fade weight.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (valid/ready): a load beat writes one slot of the table and
//   gives no response; a query beat gives exactly one rsp beat.
//   csr_write_en/csr_write_data set the slot count; write it while idle.
//   A load is written into the table as its beat is accepted. A query
//   is answered in steps: the table is scanned one slot per cycle
//   through the single read port of the keyframe memory, the current
//   and next slot are fetched, the blend operands are formed, the serial
//   divider works out the Q16 ratio where a cross-fade needs it, and the
//   output register is loaded. req_ready is low while a query is at
//   work, so the next beat is taken once the query has finished.
//   The response sits in an output register; the next beat is accepted
//   while it waits, and a finished query holds until rsp_ready frees it.
//   Reset sets the slot count to one and empties the pipeline; the table
//   contents are undefined until loaded.
// ----------------------------------------------------------------------------
module circular_keyframe_blend_selector_core
   import ckbs_pkg::*;
#(
   parameter int MAX_KEYFRAMES = MAX_KEYFRAMES_DEF
)(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ckbs_req_type     req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ckbs_rsp_type     rsp_data,
   input  logic             csr_write_en,
   input  logic [CSR_W-1:0] csr_write_data
);

   localparam int IDX_W   = $clog2(MAX_KEYFRAMES);
   localparam int CNT_W   = $clog2(MAX_KEYFRAMES + 1);
   localparam int CMP_W   = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam int ENTRY_W = TIME_W + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_RD_CUR,
      S_RD_NXT,
      S_CAP,
      S_PREP,
      S_SETUP,
      S_DIV,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      M_DIRECT,
      M_SUB_TH,
      M_UPTO_TH
   } mode_type;

   function automatic logic signed [ARITH_W-1:0] span(
      input logic signed [ARITH_W-1:0] a,
      input logic signed [ARITH_W-1:0] b
   );
      if (b < a) begin
         span = Q_ONE - a + b;
      end else begin
         span = b - a;
      end
   endfunction

   // keyframe memory: {crossfade, time}
   logic [ENTRY_W-1:0] kf_mem [MAX_KEYFRAMES];
   logic [ENTRY_W-1:0] rd_q_ff;
   logic [IDX_W-1:0]   rd_addr;
   logic               wr_en;

   state_type                 state_ff, state_in;
   mode_type                  mode_ff, mode_in;
   logic [CSR_W-1:0]          csr_count_ff, csr_count_in;
   logic [TIME_W-1:0]         now_ff, now_in;
   logic [IDX_W-1:0]          last_ff, last_in;
   logic [IDX_W-1:0]          scan_ff, scan_in;
   logic [IDX_W-1:0]          chk_idx_ff, chk_idx_in;
   logic                      chk_vld_ff, chk_vld_in;
   logic [IDX_W-1:0]          next_ff, next_in;
   logic [IDX_W-1:0]          cur_ff, cur_in;
   logic [TIME_W-1:0]         f_ff, f_in;
   logic [TIME_W-1:0]         t_ff, t_in;
   logic                      fade_ff, fade_in;
   logic signed [ARITH_W-1:0] el_ff, el_in;
   logic signed [ARITH_W-1:0] dur_ff, dur_in;
   logic signed [ARITH_W-1:0] th_ff, th_in;
   logic [BLEND_W-1:0]        blend_ff, blend_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   ckbs_rsp_type              rsp_data_ff, rsp_data_in;

   logic                      req_fire;
   logic                      slot_ok;
   logic [CMP_W-1:0]          lim;
   logic                      found;
   logic [IDX_W-1:0]          hit_idx;
   logic signed [ARITH_W-1:0] f_s, t_s, n_s;
   logic signed [ARITH_W-1:0] rf_s, rt_s;
   logic                      f_hi, t_hi;
   logic [BLEND_W-1:0]        ft_sum;
   logic                      div_start;
   logic signed [ARITH_W-1:0] div_num, div_den;
   logic                      div_done;
   logic [BLEND_W-1:0]        div_quot;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign slot_ok   = (32'(req_data.slot) < MAX_KEYFRAMES);
   assign wr_en     = req_fire && (req_data.opcode == OPCODE_LOAD) && slot_ok;

   // clamp the slot count to one .. MAX_KEYFRAMES
   assign lim = (csr_count_ff == '0) ? CMP_W'(1) : CMP_W'(csr_count_ff);

   // scan compare on the slot read in the previous cycle
   assign found   = chk_vld_ff && (rd_q_ff[TIME_W-1:0] > now_ff);
   assign hit_idx = found ? chk_idx_ff : '0;

   // blend operands
   assign f_s    = ARITH_W'(f_ff);
   assign t_s    = ARITH_W'(t_ff);
   assign n_s    = ARITH_W'(now_ff);
   assign rf_s   = Q_ONE - f_s;
   assign rt_s   = Q_ONE - t_s;
   assign f_hi   = (f_s > Q_HALF);
   assign t_hi   = (t_s > Q_HALF);
   assign ft_sum = BLEND_W'(f_ff) + BLEND_W'(t_ff);

   // address the read port
   always_comb begin
      unique case (state_ff)
         S_RD_CUR: rd_addr = cur_ff;
         S_RD_NXT: rd_addr = next_ff;
         default:  rd_addr = scan_ff;
      endcase
   end

   // keyframe memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         kf_mem[IDX_W'(req_data.slot)] <= {req_data.crossfade, req_data.key_time};
      end
      rd_q_ff <= kf_mem[rd_addr];
   end

   // divider operands, chosen by the blend rule
   always_comb begin
      div_start = 1'b0;
      div_num   = el_ff;
      div_den   = dur_ff;
      if (state_ff == S_SETUP) begin
         case (mode_ff)
            M_SUB_TH: begin
               div_start = !(el_ff < th_ff);
               div_num   = el_ff - th_ff;
               div_den   = dur_ff - th_ff;
            end
            M_UPTO_TH: begin
               div_start = !(th_ff < el_ff);
               div_num   = el_ff;
               div_den   = th_ff;
            end
            default: begin
               div_start = 1'b1;
            end
         endcase
      end
   end

   ckbs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   // sequencer
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      csr_count_in = csr_write_en ? csr_write_data : csr_count_ff;
      now_in       = now_ff;
      last_in      = last_ff;
      scan_in      = scan_ff;
      chk_idx_in   = chk_idx_ff;
      chk_vld_in   = chk_vld_ff;
      next_in      = next_ff;
      cur_in       = cur_ff;
      f_in         = f_ff;
      t_in         = t_ff;
      fade_in      = fade_ff;
      el_in        = el_ff;
      dur_in       = dur_ff;
      th_in        = th_ff;
      blend_in     = blend_ff;
      rsp_data_in  = rsp_data_ff;
      // drop the response once taken
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_data.opcode == OPCODE_QUERY)) begin
               now_in = req_data.day_fraction;
               if (lim > CMP_W'(MAX_KEYFRAMES)) begin
                  last_in = IDX_W'(MAX_KEYFRAMES - 1);
               end else begin
                  last_in = IDX_W'(lim - 1'b1);
               end
               scan_in    = '0;
               chk_vld_in = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue one read per cycle, hold at the last slot
            chk_idx_in = scan_ff;
            chk_vld_in = 1'b1;
            if (scan_ff != last_ff) begin
               scan_in = scan_ff + 1'b1;
            end
            if (found || (chk_vld_ff && (chk_idx_ff == last_ff))) begin
               next_in  = hit_idx;
               cur_in   = (hit_idx == '0) ? last_ff : hit_idx - 1'b1;
               state_in = S_RD_CUR;
            end
         end
         S_RD_CUR: begin
            state_in = S_RD_NXT;
         end
         S_RD_NXT: begin
            f_in     = rd_q_ff[TIME_W-1:0];
            fade_in  = rd_q_ff[TIME_W];
            state_in = S_CAP;
         end
         S_CAP: begin
            t_in = rd_q_ff[TIME_W-1:0];
            if (fade_ff) begin
               state_in = S_PREP;
            end else begin
               blend_in = '0;
               state_in = S_OUT;
            end
         end
         S_PREP: begin
            // elapsed time, duration and the reflected threshold
            el_in  = span(f_s, n_s);
            dur_in = span(f_s, t_s);
            if ((f_hi != t_hi) && (ft_sum > BLEND_W'(Q_ONE))) begin
               mode_in = M_SUB_TH;
               th_in   = span(f_s, rf_s);
            end else if ((f_hi != t_hi) && (ft_sum < BLEND_W'(Q_ONE))) begin
               mode_in = M_UPTO_TH;
               th_in   = span(f_s, rt_s);
            end else begin
               mode_in = M_DIRECT;
               th_in   = '0;
            end
            state_in = S_SETUP;
         end
         S_SETUP: begin
            if (div_start) begin
               state_in = S_DIV;
            end else begin
               // before the threshold the weight is zero, past it full
               blend_in = (mode_ff == M_UPTO_TH) ? BLEND_W'(Q_ONE) : '0;
               state_in = S_OUT;
            end
         end
         S_DIV: begin
            if (div_done) begin
               blend_in = div_quot;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_data_in.bottom_index = 4'(cur_ff);
               rsp_data_in.top_index    = fade_ff ? 4'(next_ff) : 4'd0;
               rsp_data_in.top_valid    = fade_ff;
               rsp_data_in.blend_factor = blend_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         csr_count_ff <= CSR_W'(1);
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         csr_count_ff <= csr_count_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
      end
      mode_ff     <= mode_in;
      now_ff      <= now_in;
      last_ff     <= last_in;
      scan_ff     <= scan_in;
      chk_idx_ff  <= chk_idx_in;
      next_ff     <= next_in;
      cur_ff      <= cur_in;
      f_ff        <= f_in;
      t_ff        <= t_in;
      fade_ff     <= fade_in;
      el_ff       <= el_in;
      dur_ff      <= dur_in;
      th_ff       <= th_in;
      blend_ff    <= blend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sim/blend_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blend_checker: response checker for the keyframe blend selector
// Watches the request, response and CSR ports, keeps its own copy of the
// keyframe table and slot count, computes the answer of every query beat
// and compares each response beat, field by field, with the oldest answer.
// ----------------------------------------------------------------------------
module blend_checker
   import ckbs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  ckbs_req_type     req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  ckbs_rsp_type     rsp_data,
   input  logic             csr_write_en,
   input  logic [CSR_W-1:0] csr_write_data,
   output int               fail_count,
   output int               answers_owed
);

   localparam int SLOTS = MAX_KEYFRAMES_DEF;
   localparam int ONE   = 65536;

   logic [TIME_W-1:0] key_times [SLOTS];
   logic              key_fades [SLOTS];
   logic [CSR_W-1:0]  slot_count;
   ckbs_rsp_type      awaited_answers [$];
   ckbs_rsp_type      oldest_answer;

   // forward distance on the day circle
   function automatic int day_span(input int from_t, input int to_t);
      if (to_t < from_t) begin
         return ONE - from_t + to_t;
      end
      return to_t - from_t;
   endfunction

   // Q16 quotient, zero for a non-positive operand, saturated to one
   function automatic int q16_ratio(input int num, input int den);
      longint quotient;
      if (den <= 0 || num <= 0) begin
         return 0;
      end
      quotient = (longint'(num) * ONE) / den;
      if (quotient > ONE) begin
         quotient = ONE;
      end
      return int'(quotient);
   endfunction

   // blend weight with the reflected-midpoint rule
   function automatic int blend_weight(input int from_t, input int to_t, input int now_t);
      int from_mirror;
      int to_mirror;
      int duration;
      int elapsed;
      int threshold;
      from_mirror = ONE - from_t;
      to_mirror   = ONE - to_t;
      duration    = day_span(from_t, to_t);
      elapsed     = day_span(from_t, now_t);
      if ((from_mirror < from_t) != (to_mirror < to_t)) begin
         if (from_mirror < to_t) begin
            threshold = day_span(from_t, from_mirror);
            if (elapsed < threshold) begin
               return 0;
            end
            return q16_ratio(elapsed - threshold, duration - threshold);
         end
         if (from_t < to_mirror) begin
            threshold = day_span(from_t, to_mirror);
            if (threshold < elapsed) begin
               return ONE;
            end
            return q16_ratio(elapsed, threshold);
         end
      end
      return q16_ratio(elapsed, duration);
   endfunction

   // scan the table in slot order and build the answer to one query
   function automatic ckbs_rsp_type predict_answer(input logic [TIME_W-1:0] day);
      ckbs_rsp_type answer;
      int           used;
      int           next_slot;
      int           cur_slot;
      bit           found;
      int           weight;
      used = (slot_count == 0) ? 1 : ((slot_count > SLOTS) ? SLOTS : int'(slot_count));
      next_slot = 0;
      found = 1'b0;
      for (int i = 0; i < used; i++) begin
         if (!found && key_times[i] > day) begin
            next_slot = i;
            found = 1'b1;
         end
      end
      cur_slot = (next_slot == 0) ? used - 1 : next_slot - 1;
      answer = '0;
      answer.bottom_index = 4'(cur_slot);
      if (key_fades[cur_slot]) begin
         weight = blend_weight(int'(key_times[cur_slot]), int'(key_times[next_slot]),
                               int'(day));
         answer.top_valid    = 1'b1;
         answer.top_index    = 4'(next_slot);
         answer.blend_factor = BLEND_W'(weight);
      end
      return answer;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      fail_count++;
   endtask

   // track config and table, queue answers, check response beats
   always @(posedge clock) begin
      if (reset) begin
         slot_count <= CSR_W'(1);
         awaited_answers.delete();
         answers_owed <= 0;
      end else begin
         if (csr_write_en) begin
            slot_count <= csr_write_data;
         end
         if (req_valid && req_ready) begin
            if (req_data.opcode == OPCODE_LOAD) begin
               key_times[req_data.slot] <= req_data.key_time;
               key_fades[req_data.slot] <= req_data.crossfade;
            end else begin
               awaited_answers.push_back(predict_answer(req_data.day_fraction));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch("response beat with no query outstanding, blend_factor",
                               int'(rsp_data.blend_factor), -1);
            end else begin
               oldest_answer = awaited_answers.pop_front();
               if (rsp_data.bottom_index !== oldest_answer.bottom_index) begin
                  report_mismatch("bottom_index", int'(rsp_data.bottom_index),
                                  int'(oldest_answer.bottom_index));
               end
               if (rsp_data.top_index !== oldest_answer.top_index) begin
                  report_mismatch("top_index", int'(rsp_data.top_index),
                                  int'(oldest_answer.top_index));
               end
               if (rsp_data.top_valid !== oldest_answer.top_valid) begin
                  report_mismatch("top_valid", int'(rsp_data.top_valid),
                                  int'(oldest_answer.top_valid));
               end
               if (rsp_data.blend_factor !== oldest_answer.blend_factor) begin
                  report_mismatch("blend_factor", int'(rsp_data.blend_factor),
                                  int'(oldest_answer.blend_factor));
               end
            end
         end
         answers_owed <= awaited_answers.size();
      end
   end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: top level for the keyframe blend selector
// Loads keyframe tables and sends time-of-day queries under several slot
// counts, with bursty requests and a stalling response sink; the checker
// beside the block predicts and compares every response beat.
// ----------------------------------------------------------------------------
module testbench;
   import ckbs_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam int          SLOTS       = MAX_KEYFRAMES_DEF;
   localparam int          SETTLE      = 64;
   localparam int          PHASES      = 12;
   localparam int          PHASE_BEATS = 72;
   localparam int          HOLD_CYCLES = 400;

   typedef enum int {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_MOSTLY} sink_mode_type;
   typedef enum int {TABLE_SORTED, TABLE_DUPLICATES, TABLE_SCRAMBLED, TABLE_FLAT}
      table_style_type;

   logic             clock          = 1'b0;
   logic             reset          = 1'b1;
   logic             req_valid      = 1'b0;
   logic             req_ready;
   ckbs_req_type     req_data       = '0;
   logic             rsp_valid;
   logic             rsp_ready      = 1'b0;
   ckbs_rsp_type     rsp_data;
   logic             csr_write_en   = 1'b0;
   logic [CSR_W-1:0] csr_write_data = '0;

   int               fail_count;
   int               answers_owed;
   int unsigned      cycle_count    = 0;
   int               burst_left     = 0;
   bit               eager          = 1'b0;
   bit               hold_off_request = 1'b0;
   logic [TIME_W-1:0] loaded_times [SLOTS];

   circular_keyframe_blend_selector_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   blend_checker answer_check (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .answers_owed   (answers_owed)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // offer one request beat, with a random gap between bursts
   task automatic offer_beat(input ckbs_req_type beat);
      int gap;
      if (!eager && burst_left == 0) begin
         gap = $urandom_range(1, 10);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) begin
         burst_left--;
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic load_keyframe(input logic [3:0] slot, input logic [TIME_W-1:0] key_time,
                                input logic fade);
      ckbs_req_type beat;
      beat.opcode       = OPCODE_LOAD;
      beat.slot         = slot;
      beat.key_time     = key_time;
      beat.crossfade    = fade;
      beat.day_fraction = TIME_W'($urandom_range(0, 65535));
      loaded_times[slot] = key_time;
      offer_beat(beat);
   endtask

   task automatic ask_time_of_day(input logic [TIME_W-1:0] day);
      ckbs_req_type beat;
      beat.opcode       = OPCODE_QUERY;
      beat.slot         = 4'($urandom_range(0, 15));
      beat.key_time     = TIME_W'($urandom_range(0, 65535));
      beat.crossfade    = 1'($urandom_range(0, 1));
      beat.day_fraction = day;
      offer_beat(beat);
   endtask

   // drop valid, wait for every answer, then let the block go quiet
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (answers_owed != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_keyframe_count(input logic [CSR_W-1:0] value);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // response sink: random stall patterns, one long hold-off on request
   initial begin : response_sink
      int            seg_len;
      sink_mode_type mode;
      forever begin
         if (hold_off_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_request = 1'b0;
         end else begin
            seg_len = $urandom_range(16, 96);
            mode = sink_mode_type'($urandom_range(0, 3));
            repeat (seg_len) begin
               case (mode)
                  SINK_OPEN: begin
                     rsp_ready <= 1'b1;
                  end
                  SINK_HALF: begin
                     rsp_ready <= 1'($urandom_range(0, 1));
                  end
                  SINK_SPARSE: begin
                     rsp_ready <= ($urandom_range(0, 3) == 0);
                  end
                  default: begin
                     rsp_ready <= ($urandom_range(0, 7) != 0);
                  end
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      table_style_type   style;
      logic [TIME_W-1:0] table_times [SLOTS];
      int                steps [SLOTS];
      int                total;
      int                base;
      int                pick;
      int                slot_pick;
      logic [TIME_W-1:0] day;
      logic [CSR_W-1:0]  count_value;

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single keyframe at reset count: zero divisor, then no cross-fade
      load_keyframe(4'd0, 16'h8000, 1'b1);
      ask_time_of_day(16'h0000);
      ask_time_of_day(16'hFFFF);
      load_keyframe(4'd0, 16'h0000, 1'b0);
      ask_time_of_day(16'h1234);
      wait_for_idle();

      // full table from time 0 to the last tick of the day
      set_keyframe_count(CSR_W'(SLOTS));
      for (int i = 0; i < SLOTS; i++) begin
         load_keyframe(4'(i), TIME_W'(i * 4369), (i != 5));
      end
      ask_time_of_day(16'h0000);
      ask_time_of_day(16'hFFFF);
      ask_time_of_day(16'h8000);
      ask_time_of_day(TIME_W'(5 * 4369 + 10));
      ask_time_of_day(16'd12345);
      wait_for_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: count_value = CSR_W'(1);
            1: count_value = CSR_W'(16);
            2: count_value = CSR_W'(2);
            3: count_value = CSR_W'(0);
            4: count_value = CSR_W'(31);
            5: count_value = CSR_W'(17);
            6: count_value = CSR_W'(16);
            default: count_value = CSR_W'($urandom_range(0, 31));
         endcase
         set_keyframe_count(count_value);
         eager = (phase == 4 || phase == 9);
         burst_left = 0;

         // build a fresh table: mostly ascending distinct times
         style = ($urandom_range(0, 9) < 7) ? TABLE_SORTED
                                            : table_style_type'($urandom_range(1, 3));
         case (style)
            TABLE_SORTED, TABLE_DUPLICATES: begin
               total = 0;
               steps[0] = 0;
               for (int i = 1; i < SLOTS; i++) begin
                  steps[i] = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(1, 4000);
                  if (style == TABLE_DUPLICATES && $urandom_range(0, 3) == 0) begin
                     steps[i] = 0;
                  end
                  total += steps[i];
               end
               pick = $urandom_range(0, 3);
               if (pick == 0) begin
                  base = 0;
               end else if (pick == 1) begin
                  base = 65535 - total;
               end else begin
                  base = $urandom_range(0, 65535 - total);
               end
               for (int i = 0; i < SLOTS; i++) begin
                  base += steps[i];
                  table_times[i] = TIME_W'(base);
               end
            end
            TABLE_SCRAMBLED: begin
               for (int i = 0; i < SLOTS; i++) begin
                  table_times[i] = TIME_W'($urandom_range(0, 65535));
               end
            end
            default: begin
               table_times[0] = TIME_W'($urandom_range(0, 65535));
               for (int i = 1; i < SLOTS; i++) begin
                  table_times[i] = table_times[0];
               end
            end
         endcase
         for (int i = 0; i < SLOTS; i++) begin
            load_keyframe(4'(i), table_times[i], ($urandom_range(0, 3) != 0));
         end

         // long response hold-off while requests keep coming
         if (phase == 1) begin
            hold_off_request = 1'b1;
         end

         // queries with random content, some stray loads as noise
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if ($urandom_range(0, 99) < 12) begin
               load_keyframe(4'($urandom_range(0, 15)), TIME_W'($urandom_range(0, 65535)),
                             1'($urandom_range(0, 1)));
            end else begin
               pick = $urandom_range(0, 7);
               slot_pick = $urandom_range(0, SLOTS - 1);
               if (pick < 4) begin
                  day = TIME_W'($urandom_range(0, 65535));
               end else if (pick == 4) begin
                  day = loaded_times[slot_pick];
               end else if (pick == 5) begin
                  day = loaded_times[slot_pick] + ($urandom_range(0, 1) ? 16'h0001 : 16'hFFFF);
               end else if (pick == 6) begin
                  day = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               end else begin
                  day = TIME_W'(32766 + $urandom_range(0, 4));
               end
               ask_time_of_day(day);
            end
         end
         wait_for_idle();
      end

      if (fail_count == 0 && answers_owed == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
